/* rtl/tpr_pkg.sv */
package tpr_pkg;

  // fixed field widths
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned HZ_W      = 32;
  localparam int unsigned PPR_W     = 8;
  localparam int unsigned RPM_W     = 16;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // default timer width
  localparam int unsigned STAMP_BITS_DEF = 32;

  // timer_hz * 60 needs six more bits
  localparam int unsigned NUM_W = HZ_W + 6;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

  // register reset values
  localparam logic [HZ_W-1:0]  HZ_RESET  = 32'd1000000;
  localparam logic [PPR_W-1:0] PPR_RESET = 8'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_HZ = 1'b0,
    CFG_PULSES   = 1'b1
  } cfg_idx_e;

endpackage

/* rtl/tpr_front.sv */
module tpr_front #(
  parameter int unsigned STAMP_BITS = tpr_pkg::STAMP_BITS_DEF,
  parameter int unsigned DEN_W      = tpr_pkg::STAMP_BITS_DEF + tpr_pkg::PPR_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [tpr_pkg::STAMP_W-1:0]   prev_stamp_i,
  input  logic [tpr_pkg::STAMP_W-1:0]   curr_stamp_i,
  input  logic [tpr_pkg::HZ_W-1:0]      timer_hz_i,
  input  logic [tpr_pkg::PPR_W-1:0]     pulses_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [tpr_pkg::NUM_W-1:0]     num_o,
  output logic [DEN_W-1:0]              den_o,
  output logic [tpr_pkg::RPM_W-1:0]     quot_o,
  output logic                          done_o
);
  import tpr_pkg::*;

  localparam int unsigned CMP_W = DEN_W + RPM_W;

  logic                  v1_q, v2_q, v3_q;
  logic                  rdy1, rdy2, rdy3;
  logic [STAMP_BITS-1:0] ticks_d, ticks_q;
  logic [NUM_W-1:0]      num2_d, num2_q, num3_q;
  logic [DEN_W-1:0]      den2_d, den2_q, den3_q;
  logic                  zero2_d, zero2_q;
  logic                  sat3_d, done3_d, done3_q;
  logic [RPM_W-1:0]      quot3_d, quot3_q;

  // per stage ready, a stage moves on when empty or when the next one moves
  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // elapsed ticks modulo the timer width
  assign ticks_d = curr_stamp_i[STAMP_BITS-1:0] - prev_stamp_i[STAMP_BITS-1:0];

  // numerator, combined divisor and degenerate cases
  assign num2_d  = NUM_W'(timer_hz_i) * NUM_W'(SEC_PER_MIN);
  assign den2_d  = DEN_W'(ticks_q) * DEN_W'(pulses_i);
  assign zero2_d = (ticks_q == '0) || (timer_hz_i == '0) || (pulses_i == '0);

  // saturation when the quotient would need more than sixteen bits
  assign sat3_d  = CMP_W'(num2_q) >= {den2_q, {RPM_W{1'b0}}};
  assign done3_d = zero2_q || sat3_d;
  assign quot3_d = (sat3_d && !zero2_q) ? {RPM_W{1'b1}} : {RPM_W{1'b0}};

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      ticks_q <= ticks_d;
    end
    if (rdy2 && v1_q) begin
      num2_q  <= num2_d;
      den2_q  <= den2_d;
      zero2_q <= zero2_d;
    end
    if (rdy3 && v2_q) begin
      num3_q  <= num2_q;
      den3_q  <= den2_q;
      quot3_q <= quot3_d;
      done3_q <= done3_d;
    end
  end

  assign valid_o = v3_q;
  assign num_o   = num3_q;
  assign den_o   = den3_q;
  assign quot_o  = quot3_q;
  assign done_o  = done3_q;

endmodule

/* rtl/tpr_div_step.sv */
module tpr_div_step #(
  parameter int unsigned DEN_W = tpr_pkg::STAMP_BITS_DEF + tpr_pkg::PPR_W,
  parameter int unsigned SHIFT = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [tpr_pkg::NUM_W-1:0]  rem_i,
  input  logic [DEN_W-1:0]           den_i,
  input  logic [tpr_pkg::RPM_W-1:0]  quot_i,
  input  logic                       done_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [tpr_pkg::NUM_W-1:0]  rem_o,
  output logic [DEN_W-1:0]           den_o,
  output logic [tpr_pkg::RPM_W-1:0]  quot_o,
  output logic                       done_o
);
  import tpr_pkg::*;

  localparam int unsigned CMP_W = DEN_W + RPM_W;

  logic             valid_q;
  logic [CMP_W-1:0] trial;
  logic [CMP_W-1:0] diff;
  logic             take;
  logic [NUM_W-1:0] rem_d, rem_q;
  logic [DEN_W-1:0] den_q;
  logic [RPM_W-1:0] quot_d, quot_q;
  logic             done_q;

  assign ready_o = !valid_q || ready_i;

  // one restoring step: subtract the shifted divisor when it fits
  assign trial = CMP_W'(den_i) << SHIFT;
  assign diff  = CMP_W'(rem_i) - trial;
  assign take  = !done_i && (CMP_W'(rem_i) >= trial);
  assign rem_d = take ? diff[NUM_W-1:0] : rem_i;

  always_comb begin
    quot_d        = quot_i;
    quot_d[SHIFT] = quot_i[SHIFT] | take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quot_q <= quot_d;
      done_q <= done_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quot_o  = quot_q;
  assign done_o  = done_q;

endmodule

/* rtl/tachometer_period_to_rpm.sv */
// Fan speed from two tachometer edge captures.
// Input channel: in_valid_i / in_stall_o carry prev_stamp_i and curr_stamp_i,
// the free-running timer values at two successive tachometer edges; the
// elapsed tick count is their difference modulo 2^STAMP_BITS.
// Output channel: out_valid_o / out_stall_i carry speed_rpm_o, which is
// floor(timer_hz * 60 / (ticks * pulses_per_rev)), saturated at 65535, and 0
// when ticks, timer_hz or pulses_per_rev is zero. One word out per word in.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 timer_hz, 1 pulses_per_rev); write only while the pipeline is empty.
// Pipeline: three front stages (tick difference, products, saturation check)
// and sixteen restoring divider stages, one quotient bit each.
// Throughput: one word per cycle while the output is taken.
// Reset empties the pipeline and loads timer_hz = 1000000, pulses_per_rev = 2.
// A stall on the output holds the last stage; earlier stages keep filling
// their empty slots, and in_stall_o rises only when every stage is occupied.
module tachometer_period_to_rpm #(
  parameter int unsigned STAMP_BITS = tpr_pkg::STAMP_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tpr_pkg::STAMP_W-1:0]    prev_stamp_i,
  input  logic [tpr_pkg::STAMP_W-1:0]    curr_stamp_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tpr_pkg::RPM_W-1:0]      speed_rpm_o,
  input  logic                           cfg_we_i,
  input  logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpr_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import tpr_pkg::*;

  localparam int unsigned DEN_W = STAMP_BITS + PPR_W;

  logic [HZ_W-1:0]  timer_hz_q;
  logic [PPR_W-1:0] pulses_q;
  logic             front_ready;

  logic             vld_w  [RPM_W+1];
  logic             rdy_w  [RPM_W+1];
  logic [NUM_W-1:0] rem_w  [RPM_W+1];
  logic [DEN_W-1:0] den_w  [RPM_W+1];
  logic [RPM_W-1:0] quot_w [RPM_W+1];
  logic             done_w [RPM_W+1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_hz_q <= HZ_RESET;
      pulses_q   <= PPR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIMER_HZ: timer_hz_q <= cfg_wdata_i[HZ_W-1:0];
        CFG_PULSES:   pulses_q   <= cfg_wdata_i[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  // tick difference, products and saturation check
  tpr_front #(
    .STAMP_BITS (STAMP_BITS),
    .DEN_W      (DEN_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (front_ready),
    .prev_stamp_i (prev_stamp_i),
    .curr_stamp_i (curr_stamp_i),
    .timer_hz_i   (timer_hz_q),
    .pulses_i     (pulses_q),
    .valid_o      (vld_w[0]),
    .ready_i      (rdy_w[0]),
    .num_o        (rem_w[0]),
    .den_o        (den_w[0]),
    .quot_o       (quot_w[0]),
    .done_o       (done_w[0])
  );

  // divider stages, most significant quotient bit first
  for (genvar k = 0; k < RPM_W; k++) begin : g_div
    tpr_div_step #(
      .DEN_W (DEN_W),
      .SHIFT (RPM_W - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_w[k]),
      .ready_o (rdy_w[k]),
      .rem_i   (rem_w[k]),
      .den_i   (den_w[k]),
      .quot_i  (quot_w[k]),
      .done_i  (done_w[k]),
      .valid_o (vld_w[k+1]),
      .ready_i (rdy_w[k+1]),
      .rem_o   (rem_w[k+1]),
      .den_o   (den_w[k+1]),
      .quot_o  (quot_w[k+1]),
      .done_o  (done_w[k+1])
    );
  end

  assign rdy_w[RPM_W] = !out_stall_i;
  assign in_stall_o   = !front_ready;
  assign out_valid_o  = vld_w[RPM_W];
  assign speed_rpm_o  = quot_w[RPM_W];

  // the input can only be held off when the pipeline is full up to the output
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while the output stage is empty");

  // a finished division leaves a remainder below the divisor
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_w[RPM_W]) |-> (rem_w[RPM_W] < NUM_W'(den_w[RPM_W])
      || den_w[RPM_W] > DEN_W'({NUM_W{1'b1}})))
    else $error("divider remainder not below divisor");

  // a degenerate or saturated word never touches the quotient in the divider
  a_done_quot_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_w[RPM_W]) |->
      (speed_rpm_o == '0 || speed_rpm_o == {RPM_W{1'b1}}))
    else $error("bypassed word carries a partial quotient");

endmodule

/* test/tb_tachometer_period_to_rpm.sv */
`timescale 1ns / 1ps

module tb_tachometer_period_to_rpm;
  import tpr_pkg::*;

  localparam int unsigned TIMER_BITS   = STAMP_BITS_DEF;
  localparam int unsigned PIPE_DEPTH   = 19;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned WORDS_PER_SETTING = 166;
  localparam int unsigned SETTINGS_RUN = 8;
  localparam int unsigned REPORT_MAX   = 10;
  localparam logic [63:0] RPM_MAX      = 64'd65535;

  // expected speeds, worked out from the captures and the register copies
  class rpm_scoreboard;
    logic [HZ_W-1:0]  hz;
    logic [PPR_W-1:0] ppr;
    logic [RPM_W-1:0] speeds_due[$];
    int               faults;

    function new();
      hz     = HZ_RESET;
      ppr    = PPR_RESET;
      faults = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_TIMER_HZ: hz = value[HZ_W-1:0];
        CFG_PULSES:   ppr = value[PPR_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(hz * 60 / ticks / ppr), clamped, zero on degenerate input
    function logic [RPM_W-1:0] speed_of(logic [STAMP_W-1:0] prev, logic [STAMP_W-1:0] curr);
      logic [63:0] mask;
      logic [63:0] ticks;
      logic [63:0] quot;
      mask  = (64'd1 << TIMER_BITS) - 64'd1;
      ticks = (({32'd0, curr} & mask) - ({32'd0, prev} & mask)) & mask;
      if (ticks == 64'd0 || hz == '0 || ppr == '0) return '0;
      quot = ({32'd0, hz} * {58'd0, SEC_PER_MIN}) / ticks;
      quot = quot / {56'd0, ppr};
      if (quot > RPM_MAX) return '1;
      return quot[RPM_W-1:0];
    endfunction

    function void note_capture(logic [STAMP_W-1:0] prev, logic [STAMP_W-1:0] curr);
      speeds_due.push_back(speed_of(prev, curr));
    endfunction

    function void check_speed(logic [RPM_W-1:0] got);
      logic [RPM_W-1:0] want;
      if (speeds_due.size() == 0) begin
        faults++;
        if (faults <= REPORT_MAX) $display("unexpected speed word: actual %0d", got);
        return;
      end
      want = speeds_due.pop_front();
      if (want !== got) begin
        faults++;
        if (faults <= REPORT_MAX)
          $display("speed_rpm mismatch: expected %0d actual %0d", want, got);
      end
    endfunction

    function int pending();
      return speeds_due.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [STAMP_W-1:0]   prev_stamp_i;
  logic [STAMP_W-1:0]   curr_stamp_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [RPM_W-1:0]     speed_rpm_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  rpm_scoreboard sb = new();
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  bit            hold_req = 1'b0;
  int unsigned   cycle_count = 0;

  tachometer_period_to_rpm #(
    .STAMP_BITS(TIMER_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .prev_stamp_i(prev_stamp_i),
    .curr_stamp_i(curr_stamp_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .speed_rpm_o (speed_rpm_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // note accepted captures and check accepted speed words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_capture(prev_stamp_i, curr_stamp_i);
      if (out_valid_o && !out_stall_i) sb.check_speed(speed_rpm_o);
    end
  end

  // output side: random stall, plus a long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // offer one capture pair and hold it until taken
  task automatic offer(input logic [STAMP_W-1:0] prev, input logic [STAMP_W-1:0] curr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    prev_stamp_i <= prev;
    curr_stamp_i <= curr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop offering until every speed word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // one write, then a wait with the enable low before returning
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  // both registers, written with the pipeline empty
  task automatic configure(input logic [HZ_W-1:0] hz, input logic [PPR_W-1:0] ppr);
    drain();
    write_reg(CFG_TIMER_HZ, hz);
    write_reg(CFG_PULSES, {24'($urandom()), ppr});
  endtask

  task automatic set_pace(input int unsigned mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 69; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 69; end
      default: begin idle_pct = 9; stall_pct = 9; end
    endcase
  endtask

  // random pair, with the tick span spread over several magnitudes
  function automatic void pick_stamps(output logic [STAMP_W-1:0] prev,
                                      output logic [STAMP_W-1:0] curr);
    logic [STAMP_W-1:0] span;
    case ($urandom_range(9))
      0:       span = '0;
      1, 2:    span = $urandom_range(1000);
      3, 4:    span = $urandom_range(60000);
      5:       span = $urandom_range(32'h0010_0000);
      6, 7:    span = $urandom() >> $urandom_range(31);
      default: span = $urandom();
    endcase
    prev = $urandom();
    curr = prev + span;
  endfunction

  initial begin
    logic [STAMP_W-1:0] prev;
    logic [STAMP_W-1:0] curr;
    logic [HZ_W-1:0]    hz_v;
    logic [PPR_W-1:0]   ppr_v;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    prev_stamp_i <= '0;
    curr_stamp_i <= '0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_TIMER_HZ;
    cfg_wdata_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words on the reset settings
    offer(32'h0000_0000, 32'h0000_0000);
    offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(32'h0000_0000, 32'h0000_0001);
    offer(32'h0000_0001, 32'h0000_0000);
    offer(32'h0000_0000, 32'hFFFF_FFFF);
    offer(32'hFFFF_FFF0, 32'h0000_0010);
    offer(32'h0000_0000, 32'd457);
    offer(32'h0000_0000, 32'd458);
    offer(32'hAAAA_AAAA, 32'h5555_5555);
    offer(32'h5555_5555, 32'hAAAA_AAAA);
    offer(32'h1234_5678, 32'h1234_5678 + 32'd1000000);

    // zero frequency
    configure(32'd0, PPR_RESET);
    offer(32'h0000_0000, 32'h0000_0001);
    offer(32'd100, 32'd50);

    // zero pulses at the highest frequency
    configure(32'hFFFF_FFFF, 8'd0);
    offer(32'h0000_0000, 32'h0000_0001);
    offer(32'h0000_0000, 32'd1000);

    // highest frequency and pulse count
    configure(32'hFFFF_FFFF, 8'hFF);
    offer(32'h0000_0000, 32'hFFFF_FFFF);
    offer(32'h0000_0000, 32'h0000_0001);
    offer(32'h0000_0000, 32'h0100_0000);

    // lowest non-zero settings
    configure(32'd1, 8'd1);
    offer(32'h0000_0000, 32'd60);
    offer(32'h0000_0000, 32'd61);
    offer(32'hFFFF_FFFF, 32'h0000_0000);

    // random words over several settings and pacing modes
    for (int s = 0; s < SETTINGS_RUN; s++) begin
      case (s)
        0:       begin hz_v = HZ_RESET;     ppr_v = PPR_RESET; end
        1:       begin hz_v = 32'hFFFF_FFFF; ppr_v = 8'hFF;     end
        2:       begin hz_v = 32'd1;        ppr_v = 8'd1;      end
        3:       begin hz_v = 32'd0;        ppr_v = 8'd3;      end
        4:       begin hz_v = 32'd25000000; ppr_v = 8'd0;      end
        5:       begin hz_v = 32'd32768;    ppr_v = 8'd4;      end
        default: begin hz_v = $urandom();   ppr_v = 8'($urandom_range(255, 1)); end
      endcase
      configure(hz_v, ppr_v);
      set_pace(s % 4);
      // long output hold-off while words keep coming, so the input stalls
      if (s == 0) hold_req = 1'b1;
      for (int n = 0; n < WORDS_PER_SETTING; n++) begin
        if (n == WORDS_PER_SETTING / 2) drain();
        pick_stamps(prev, curr);
        offer(prev, curr);
      end
    end

    drain();
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tpr_pkg.sv
rtl/tpr_front.sv
rtl/tpr_div_step.sv
rtl/tachometer_period_to_rpm.sv
test/tb_tachometer_period_to_rpm.sv
